[sv/dq_pkg.sv]
package dq_pkg;

    // Ring geometry
    localparam int DEPTH  = 16;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int CMD_W  = 3;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_DUMP       = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    // One result word headed for the output queue
    typedef struct packed {
        status_t                    status;
        logic signed [WORD_W-1:0]   word;
        logic                       last;
    } res_t;

    // Result in flight while the slot read completes
    typedef struct packed {
        logic    valid;
        status_t status;
        logic    from_ram;
        logic    last;
    } pend_t;

    // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH))
            sum = sum - (CW+1)'(DEPTH);
        return sum[AW-1:0];
    endfunction

endpackage

[sv/dq_ram.sv]
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

[sv/dq_out_fifo.sv]
module dq_out_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  dq_pkg::res_t   wr_res,
    input  logic           rd,
    output logic           valid,
    output dq_pkg::res_t   head,
    output logic [1:0]     level
);

    import dq_pkg::*;

    logic [1:0] level_reg, level_next;
    res_t       e0_reg, e0_next;
    res_t       e1_reg, e1_next;

    // Two-entry queue, head always in e0; writer never writes when full
    always_comb
    begin
        e0_next    = e0_reg;
        e1_next    = e1_reg;
        level_next = level_reg + 2'(wr) - 2'(rd);
        case (level_reg)
            2'd0:
            begin
                if (wr)
                    e0_next = wr_res;
            end
            2'd1:
            begin
                if (wr && rd)
                    e0_next = wr_res;
                else if (wr)
                    e1_next = wr_res;
            end
            2'd2:
            begin
                if (rd)
                    e0_next = e1_reg;
            end
            default:
            begin
                e0_next = e0_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= '0;
        else
            level_reg <= level_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    assign valid = (level_reg != 2'd0);
    assign head  = e0_reg;
    assign level = level_reg;

endmodule

[sv/double_ended_queue_core.sv]
// Deque of signed 32-bit words in a 16-slot ring with front index and count.
// Results pass the pending register, then the output queue, to the master side.
// One push or pop per cycle while the output queue has room; a dump starts, then
// reads each stored word through the single slot-memory read port, taking no commands.
// Reset (rst_n, async active low) clears front, count and the output queue;
// slot contents stay undefined, no clearing pass is run.
module double_ended_queue_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic signed [dq_pkg::WORD_W-1:0]    s_tdata,   // [31:0] value
    input  logic        [dq_pkg::CMD_W-1:0]     s_tuser,   // [2:0] command
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [dq_pkg::WORD_W-1:0]    m_tdata,   // [31:0] word
    output logic        [dq_pkg::STAT_W-1:0]    m_tuser,   // [1:0] status
    output logic                                m_tlast    // last
);

    import dq_pkg::*;

    state_t        state_reg, state_next;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    pend_t         pend_reg, pend_next;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic          in_acc, m_pop, issue_ok, full, empty;
    logic          dump_start, dump_done;
    logic [2:0]    occ, lim;
    logic [1:0]    fifo_level;
    cmd_t          cmd;
    res_t          wr_res, head;

    assign cmd    = cmd_t'(s_tuser);
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign m_pop  = m_tvalid & m_tready;

    // Room check: queued + in-flight results must fit after this cycle's pop
    assign occ      = {1'b0, fifo_level} + {2'b0, pend_reg.valid};
    assign lim      = 3'd1 + {2'b0, m_pop};
    assign issue_ok = (occ <= lim);

    assign s_tready = (state_reg == ST_IDLE) && issue_ok;
    assign in_acc   = s_tvalid & s_tready;

    // Command decode and ring update; a slot write and a later read of it
    // never share an edge, so no forwarding is needed
    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = front_reg;
        ram_re     = 1'b0;
        ram_raddr  = front_reg;
        front_next = front_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pend_next  = '0;
        dump_start = 1'b0;
        dump_done  = 1'b0;

        if (state_reg == ST_IDLE)
        begin
            if (in_acc)
            begin
                case (cmd)
                    CMD_PUSH_FRONT, CMD_PUSH_REAR:
                    begin
                        pend_next.valid = 1'b1;
                        pend_next.last  = 1'b1;
                        if (full)
                            pend_next.status = STAT_FULL;
                        else
                        begin
                            pend_next.status = STAT_OK;
                            ram_we           = 1'b1;
                            count_next       = count_reg + CW'(1);
                            if (cmd == CMD_PUSH_FRONT)
                            begin
                                front_next = ring_add(front_reg, CW'(DEPTH - 1));
                                ram_waddr  = front_next;
                            end
                            else
                                ram_waddr = ring_add(front_reg, count_reg);
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_REAR:
                    begin
                        pend_next.valid = 1'b1;
                        pend_next.last  = 1'b1;
                        if (empty)
                            pend_next.status = STAT_EMPTY;
                        else
                        begin
                            pend_next.status   = STAT_OK;
                            pend_next.from_ram = 1'b1;
                            ram_re             = 1'b1;
                            count_next         = count_reg - CW'(1);
                            if (cmd == CMD_POP_FRONT)
                            begin
                                ram_raddr  = front_reg;
                                front_next = ring_add(front_reg, CW'(1));
                            end
                            else
                                ram_raddr = ring_add(front_reg, count_reg - CW'(1));
                        end
                    end
                    CMD_DUMP:
                    begin
                        if (empty)
                        begin
                            pend_next.valid  = 1'b1;
                            pend_next.status = STAT_EMPTY;
                            pend_next.last   = 1'b1;
                        end
                        else
                        begin
                            dump_start = 1'b1;
                            idx_next   = '0;
                        end
                    end
                    default:
                    begin
                        pend_next = '0;
                    end
                endcase
            end
        end
        else if (issue_ok)
        begin
            // Dump walk: one slot read per cycle while the output queue has room, front to rear
            ram_re             = 1'b1;
            ram_raddr          = ring_add(front_reg, CW'(idx_reg));
            pend_next.valid    = 1'b1;
            pend_next.status   = STAT_OK;
            pend_next.from_ram = 1'b1;
            pend_next.last     = ((CW'(idx_reg) + CW'(1)) == count_reg);
            dump_done          = pend_next.last;
            idx_next           = idx_reg + AW'(1);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (dump_start)
                    state_next = ST_DUMP;
            end
            ST_DUMP:
            begin
                if (dump_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
        end
    end

    // Slot store
    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result assembly: word is zero unless it came from a slot read
    always_comb
    begin
        wr_res.status = pend_reg.status;
        wr_res.word   = pend_reg.from_ram ? ram_rdata : '0;
        wr_res.last   = pend_reg.last;
    end

    dq_out_fifo u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (pend_reg.valid),
        .wr_res (wr_res),
        .rd     (m_pop),
        .valid  (m_tvalid),
        .head   (head),
        .level  (fifo_level)
    );

    assign m_tdata = head.word;
    assign m_tuser = head.status;
    assign m_tlast = head.last;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count exceeds depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg.valid |-> (fifo_level != 2'd2))
        else $error("result written into full output queue");

    a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> !s_tready)
        else $error("input taken during dump");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) && !full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not grow count");

endmodule

[bench/double_ended_queue_core_tb.sv]
module double_ended_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 120;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES    = 10;
    localparam int STALL_LIMIT    = 3000;

    // Command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN  = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_ZERO = 32'sh0000_0000;
    localparam logic signed [WORD_W-1:0] WORD_ONES = 32'shFFFF_FFFF;

    // Deque shadow and expected-word store
    class deque_scoreboard;
        logic signed [WORD_W-1:0] ring [DEPTH];
        int   head       = 0;
        int   fill       = 0;
        res_t expected_q [$];
        int   errors     = 0;
        int   checked    = 0;
        int   n_cmds     = 0;
        int   n_dumps    = 0;
        int   n_full     = 0;
        int   n_empty    = 0;
        int   n_ignored  = 0;

        function void add_result(status_t status, logic signed [WORD_W-1:0] word,
                                 logic last);
            res_t r;
            r.status = status;
            r.word   = word;
            r.last   = last;
            expected_q.push_back(r);
        endfunction

        // Apply one accepted command to the shadow and queue its results
        function void note_command(logic [CMD_W-1:0] cmd, logic signed [WORD_W-1:0] value);
            logic signed [WORD_W-1:0] popped;
            if (cmd <= CMD_DUMP)
                n_cmds++;
            case (cmd)
                CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                    if (fill >= DEPTH) begin
                        n_full++;
                        add_result(STAT_FULL, WORD_ZERO, 1'b1);
                    end
                    else begin
                        if (cmd == CMD_PUSH_FRONT) begin
                            head       = (head + DEPTH - 1) % DEPTH;
                            ring[head] = value;
                        end
                        else
                            ring[(head + fill) % DEPTH] = value;
                        fill++;
                        add_result(STAT_OK, WORD_ZERO, 1'b1);
                    end
                end
                CMD_POP_FRONT, CMD_POP_REAR: begin
                    if (fill == 0) begin
                        n_empty++;
                        add_result(STAT_EMPTY, WORD_ZERO, 1'b1);
                    end
                    else begin
                        if (cmd == CMD_POP_FRONT) begin
                            popped = ring[head];
                            head   = (head + 1) % DEPTH;
                        end
                        else
                            popped = ring[(head + fill - 1) % DEPTH];
                        fill--;
                        add_result(STAT_OK, popped, 1'b1);
                    end
                end
                CMD_DUMP: begin
                    n_dumps++;
                    if (fill == 0) begin
                        n_empty++;
                        add_result(STAT_EMPTY, WORD_ZERO, 1'b1);
                    end
                    else
                        for (int i = 0; i < fill; i++)
                            add_result(STAT_OK, ring[(head + i) % DEPTH], i == fill - 1);
                end
                default:
                    n_ignored++;
            endcase
        endfunction

        // Compare one output word against the oldest expectation
        function void check_word(logic [STAT_W-1:0] status, logic signed [WORD_W-1:0] word,
                                 logic last);
            res_t e;
            checked++;
            if (expected_q.size() == 0) begin
                $error("unexpected output word: status %0d word %0d last %0d",
                       status, word, last);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, status);
                errors++;
            end
            if (word !== e.word) begin
                $error("word: expected %0d, actual %0d", e.word, word);
                errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d, actual %0d", e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic signed [WORD_W-1:0] s_tdata  = '0;
    logic        [CMD_W-1:0]  s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic signed [WORD_W-1:0] m_tdata;
    logic        [STAT_W-1:0] m_tuser;
    logic                     m_tlast;

    deque_scoreboard sb = new;

    int tx_idle_pct   = 19;
    int rx_idle_pct   = 84;
    int hold_requests = 0;
    int items_sent    = 0;
    int idle_cycles   = 0;

    double_ended_queue_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Offer one command word, idling first at the current rate
    task automatic offer_command(input logic [CMD_W-1:0] cmd,
                                 input logic signed [WORD_W-1:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (cmd <= CMD_DUMP)
            items_sent++;
    endtask

    // Sender pauses until every expected result has come
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [CMD_W-1:0] random_push();
        return $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
    endfunction

    function automatic logic [CMD_W-1:0] random_pop();
        return $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
    endfunction

    // Receiver: random backpressure, plus long hold-offs on request
    initial begin : rx_side
        int holds_served;
        holds_served = 0;
        forever begin
            @(posedge clk);
            if (hold_requests != holds_served) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Handshake monitor
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_command(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_word(m_tuser, m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog on cycles with no handshake on either side
    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int kind;
        int len;
        int phase;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty deque on every read command
        offer_command(CMD_POP_FRONT, $urandom);
        offer_command(CMD_POP_REAR, $urandom);
        offer_command(CMD_DUMP, $urandom);

        // Extremes at both ends, front push wraps the ring
        offer_command(CMD_PUSH_FRONT, WORD_MAX);
        offer_command(CMD_PUSH_REAR, WORD_MIN);
        offer_command(CMD_PUSH_FRONT, WORD_ONES);
        offer_command(CMD_PUSH_REAR, WORD_ZERO);

        // Fill up, then try both pushes on a full deque
        for (int i = 4; i < DEPTH; i++)
            offer_command(random_push(), $urandom);
        offer_command(CMD_PUSH_FRONT, $urandom);
        offer_command(CMD_PUSH_REAR, $urandom);
        offer_command(CMD_DUMP, $urandom);
        offer_command(CMD_POP_FRONT, $urandom);
        offer_command(CMD_POP_REAR, $urandom);

        // Codes the block ignores
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            offer_command(c[CMD_W-1:0], $urandom);

        // Random bursts, in three backpressure phases
        items_sent = 0;
        phase      = 1;
        while (items_sent < RANDOM_ITEMS) begin
            if (phase == 1 && items_sent >= RANDOM_ITEMS / 3) begin
                drain_results();
                tx_idle_pct <= 84;
                rx_idle_pct <= 19;
                phase = 2;
            end
            else if (phase == 2 && items_sent >= 2 * RANDOM_ITEMS / 3) begin
                drain_results();
                tx_idle_pct   <= 0;
                rx_idle_pct   <= 0;
                hold_requests <= hold_requests + 1;
                phase = 3;
            end

            kind = $urandom_range(99);
            if (kind < 30) begin
                // fill toward full, often past it
                len = $urandom_range(DEPTH + 2, 4);
                for (int i = 0; i < len; i++)
                    offer_command(random_push(), $urandom);
                if ($urandom_range(1))
                    offer_command(CMD_DUMP, $urandom);
            end
            else if (kind < 55) begin
                // drain toward empty, often past it
                len = $urandom_range(DEPTH + 1, 4);
                for (int i = 0; i < len; i++)
                    offer_command(random_pop(), $urandom);
            end
            else if (kind < 90) begin
                len = $urandom_range(8, 1);
                for (int i = 0; i < len; i++)
                    offer_command(CMD_W'($urandom_range(CMD_DUMP, CMD_PUSH_FRONT)), $urandom);
            end
            else
                offer_command(CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), $urandom);
        end
        s_tvalid <= 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d commands (%0d dumps, %0d refused pushes, %0d empty replies, %0d ignored)",
                 sb.n_cmds, sb.n_dumps, sb.n_full, sb.n_empty, sb.n_ignored);
        $display("Checked %0d output words across three backpressure phases", sb.checked);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
